// ===== rtl/core/tbps_pkg.sv =====
// Shared types, constants and helpers for the tilt-ball physics step.
// No dependencies; used by tbps_axis and tilt_ball_physics_step.
package tbps_pkg;

    // Default position fraction width (8.8 fixed point)
    localparam int FRACTION_BITS = 8;

    // Register indexes of the configuration port
    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_OFFSET_X        = 3'd0;
    localparam cfg_index_t CFG_OFFSET_Y        = 3'd1;
    localparam cfg_index_t CFG_FRICTION        = 3'd2;
    localparam cfg_index_t CFG_SHAKE_THRESHOLD = 3'd3;
    localparam cfg_index_t CFG_MAX_COLUMN      = 3'd4;
    localparam cfg_index_t CFG_MAX_ROW         = 3'd5;

    localparam int CFG_DATA_W = 18;

    // Reset values
    localparam logic [7:0]  FRICTION_RESET        = 8'd250;
    localparam logic [17:0] SHAKE_THRESHOLD_RESET = 18'd2500;
    localparam logic [7:0]  MAX_COLUMN_RESET      = 8'd19;
    localparam logic [7:0]  MAX_ROW_RESET         = 8'd14;
    localparam int          START_COLUMN          = 9;
    localparam int          START_ROW             = 7;

    // Configuration seen by one axis
    typedef struct packed {
        logic [7:0] friction;
        logic [7:0] max_cell;
    } axis_cfg_t;

    // Negate and halve, truncating toward zero
    function automatic logic signed [15:0] neg_half(logic signed [15:0] v);
        logic signed [16:0] n;
        logic signed [16:0] r;
        n = 17'sd0 - $signed({v[15], v});
        r = n + $signed({16'b0, n[16]});
        return r[16:1];
    endfunction

endpackage

// ===== rtl/core/tbps_axis.sv =====
// One-axis velocity and position update: saturate, damp, integrate, bounce.
// Depends on tbps_pkg.
module tbps_axis #(
    parameter int FRACTION_BITS = tbps_pkg::FRACTION_BITS,
    localparam int POS_W = 8 + FRACTION_BITS
) (
    input  logic [POS_W-1:0]     pos,
    input  logic signed [15:0]   vel,
    input  logic signed [8:0]    accel,
    input  tbps_pkg::axis_cfg_t  cfg,
    output logic [POS_W-1:0]     pos_next,
    output logic signed [15:0]   vel_next
);

    localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 2;

    logic signed [16:0]      vel_sum;
    logic signed [15:0]      vel_sat;
    logic signed [24:0]      prod;
    logic signed [15:0]      vel_damp;
    logic signed [SUM_W-1:0] pos_sum;
    logic signed [SUM_W-1:0] pos_low;
    logic signed [SUM_W-1:0] wall_ext;
    logic [POS_W-1:0]        wall;
    logic                    hit_low;
    logic                    hit_high;
    logic signed [15:0]      vel_low;

    assign vel_sum = $signed({vel[15], vel}) + $signed({{8{accel[8]}}, accel});

    always_comb
    begin
        if (vel_sum[16] != vel_sum[15])
            vel_sat = vel_sum[16] ? 16'sh8000 : 16'sh7fff;
        else
            vel_sat = vel_sum[15:0];
    end

    // Floor of v * f / 256: the bit-select of the product is an arithmetic shift
    assign prod     = vel_sat * $signed({1'b0, cfg.friction});
    assign vel_damp = prod[23:8];

    assign pos_sum  = $signed({{(SUM_W-POS_W){1'b0}}, pos})
                    + $signed({{(SUM_W-16){vel_damp[15]}}, vel_damp});
    assign wall     = {cfg.max_cell, {FRACTION_BITS{1'b0}}};
    assign wall_ext = $signed({{(SUM_W-POS_W){1'b0}}, wall});

    // Low wall first, then high wall on the clamped value
    assign hit_low  = pos_sum[SUM_W-1];
    assign pos_low  = hit_low ? '0 : pos_sum;
    assign hit_high = (pos_low >= wall_ext);

    assign vel_low  = hit_low  ? tbps_pkg::neg_half(vel_damp) : vel_damp;
    assign vel_next = hit_high ? tbps_pkg::neg_half(vel_low)  : vel_low;
    assign pos_next = hit_high ? wall : pos_low[POS_W-1:0];

endmodule

// ===== rtl/core/tilt_ball_physics_step.sv =====
// Tilt-ball physics step: shake detect, velocity damping, position update.
// An input word waits in the input register until the result register is free
// or draining, then is written to the result register. Throughput: one word per
// cycle while the sink takes words; the tbps_axis state update is combinational.
// Reset: config to defaults, ball at cell (9, 7), velocities and previous sample zero,
// both pipeline stages empty.
// Depends on tbps_pkg and tbps_axis.
module tilt_ball_physics_step #(
    parameter int FRACTION_BITS = tbps_pkg::FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // accel_x[7:0], accel_y[15:8], accel_z[23:16]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cell_column[7:0], cell_row[15:8]
    output logic        m_tuser,   // shake[0]
    // configuration write port
    input  logic                             cfg_we,
    input  tbps_pkg::cfg_index_t             cfg_index,
    input  logic [tbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = 8 + FRACTION_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [7:0] offset_x_reg;
    logic signed [7:0] offset_y_reg;
    logic [7:0]        friction_reg;
    logic [17:0]       shake_threshold_reg;
    logic [7:0]        max_column_reg;
    logic [7:0]        max_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg        <= '0;
            offset_y_reg        <= '0;
            friction_reg        <= tbps_pkg::FRICTION_RESET;
            shake_threshold_reg <= tbps_pkg::SHAKE_THRESHOLD_RESET;
            max_column_reg      <= tbps_pkg::MAX_COLUMN_RESET;
            max_row_reg         <= tbps_pkg::MAX_ROW_RESET;
        end
        else if (cfg_we)
        begin
            // indexes past the last register drop silently
            unique case (cfg_index)
                tbps_pkg::CFG_OFFSET_X:        offset_x_reg        <= cfg_data[7:0];
                tbps_pkg::CFG_OFFSET_Y:        offset_y_reg        <= cfg_data[7:0];
                tbps_pkg::CFG_FRICTION:        friction_reg        <= cfg_data[7:0];
                tbps_pkg::CFG_SHAKE_THRESHOLD: shake_threshold_reg <= cfg_data[17:0];
                tbps_pkg::CFG_MAX_COLUMN:      max_column_reg      <= cfg_data[7:0];
                tbps_pkg::CFG_MAX_ROW:         max_row_reg         <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register, compute, result register.
    // The compute step fires when an input word is held and the result
    // register is free or being drained this cycle, so one word moves
    // through per cycle while the sink keeps taking words.
    // ---------------------------------------------------------------
    logic        in_valid_reg;
    logic [23:0] in_data_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_shake_reg;
    logic        out_free;
    logic        fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
    end

    // ---------------------------------------------------------------
    // Shake detect: energy of the change from the previous raw sample
    // ---------------------------------------------------------------
    logic signed [7:0]  accel_x;
    logic signed [7:0]  accel_y;
    logic signed [7:0]  accel_z;
    logic signed [7:0]  prev_x_reg;
    logic signed [7:0]  prev_y_reg;
    logic signed [7:0]  prev_z_reg;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [8:0]  dz;
    logic signed [17:0] sq_x;
    logic signed [17:0] sq_y;
    logic signed [17:0] sq_z;
    logic [17:0]        motion;
    logic               shake_next;

    assign accel_x = in_data_reg[7:0];
    assign accel_y = in_data_reg[15:8];
    assign accel_z = in_data_reg[23:16];

    assign dx = $signed({accel_x[7], accel_x}) - $signed({prev_x_reg[7], prev_x_reg});
    assign dy = $signed({accel_y[7], accel_y}) - $signed({prev_y_reg[7], prev_y_reg});
    assign dz = $signed({accel_z[7], accel_z}) - $signed({prev_z_reg[7], prev_z_reg});

    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign sq_z = dz * dz;

    // each square is at most 2^16, so the sum fits 18 bits
    assign motion     = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
    assign shake_next = (motion > shake_threshold_reg);

    // ---------------------------------------------------------------
    // Ball state and per-axis update
    // ---------------------------------------------------------------
    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic signed [15:0]  vel_x_reg;
    logic signed [15:0]  vel_y_reg;
    logic [POS_W-1:0]    pos_x_next;
    logic [POS_W-1:0]    pos_y_next;
    logic signed [15:0]  vel_x_next;
    logic signed [15:0]  vel_y_next;
    logic signed [8:0]   cal_x;
    logic signed [8:0]   cal_y;
    tbps_pkg::axis_cfg_t cfg_x;
    tbps_pkg::axis_cfg_t cfg_y;

    // calibrated tilt
    assign cal_x = $signed({accel_x[7], accel_x}) - $signed({offset_x_reg[7], offset_x_reg});
    assign cal_y = $signed({accel_y[7], accel_y}) - $signed({offset_y_reg[7], offset_y_reg});

    assign cfg_x = '{friction: friction_reg, max_cell: max_column_reg};
    assign cfg_y = '{friction: friction_reg, max_cell: max_row_reg};

    tbps_axis #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_x (
        .pos      (pos_x_reg),
        .vel      (vel_x_reg),
        .accel    (cal_x),
        .cfg      (cfg_x),
        .pos_next (pos_x_next),
        .vel_next (vel_x_next)
    );

    tbps_axis #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_y (
        .pos      (pos_y_reg),
        .vel      (vel_y_reg),
        .accel    (cal_y),
        .cfg      (cfg_y),
        .pos_next (pos_y_next),
        .vel_next (vel_y_next)
    );

    // Advance the state once per word that fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= POS_W'(tbps_pkg::START_COLUMN) << FRACTION_BITS;
            pos_y_reg  <= POS_W'(tbps_pkg::START_ROW) << FRACTION_BITS;
            vel_x_reg  <= '0;
            vel_y_reg  <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
        end
        else if (fire)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            vel_x_reg  <= vel_x_next;
            vel_y_reg  <= vel_y_next;
            prev_x_reg <= accel_x;
            prev_y_reg <= accel_y;
            prev_z_reg <= accel_z;
        end
    end

    // ---------------------------------------------------------------
    // Result register: hold until the sink takes the word
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg  <= {pos_y_next[POS_W-1:FRACTION_BITS],
                              pos_x_next[POS_W-1:FRACTION_BITS]};
            out_shake_reg <= shake_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_shake_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a held input word is never dropped before it fires
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("input word lost without firing");

    // every fired word shows up as a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("fired word missing from result register");

    // after a step the ball sits inside the walls
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (pos_x_reg <= {max_column_reg, {FRACTION_BITS{1'b0}}}
               && pos_y_reg <= {max_row_reg, {FRACTION_BITS{1'b0}}}))
        else $error("ball position beyond wall after step");

endmodule
